// ===== rtl/core/bhil_pkg.sv =====
// ----------------------------------------------------------------------------
// bhil_pkg
// Shared types for the Brent double-hashing insert/lookup table.
// ----------------------------------------------------------------------------
package bhil_pkg;

    localparam int unsigned SLOT_COUNT = 31;
    localparam int unsigned KEY_W      = 16;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned OUT_W      = 5;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t          opcode;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [OUT_W-1:0] slot;
        logic [OUT_W-1:0] probes;
    } rsp_t;

endpackage

// ===== rtl/core/bhil_hash.sv =====
// ----------------------------------------------------------------------------
// bhil_hash
// Sequential home/step generator: key mod size and quotient mod size through
// one shared reciprocal multiplier, used in two passes.
// ----------------------------------------------------------------------------
module bhil_hash #(
    parameter int unsigned SLOT_COUNT = 31,
    parameter int unsigned KEY_WIDTH  = 16,
    parameter int unsigned AW         = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [KEY_WIDTH-1:0] key,
    output logic                 done,
    output logic [AW-1:0]        home,
    output logic [AW-1:0]        step
);

    localparam int unsigned     SH    = KEY_WIDTH + $clog2(SLOT_COUNT);
    localparam int unsigned     MW    = KEY_WIDTH + 2;
    localparam int unsigned     PW    = KEY_WIDTH + MW;
    localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(SLOT_COUNT) - 64'd1)
                                        / 64'(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_QUO,
        S_REM,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [KEY_WIDTH-1:0] num_reg, num_next;
    logic [KEY_WIDTH-1:0] quo_reg, quo_next;
    logic [AW-1:0]        home_reg, home_next;
    logic [AW-1:0]        step_reg, step_next;
    logic                 small_reg, small_next;
    logic                 pass_reg, pass_next;
    logic [PW-1:0]        prod;
    logic [KEY_WIDTH-1:0] quo_calc;
    logic [PW-1:0]        back;
    logic [KEY_WIDTH-1:0] rem_calc;

    assign prod     = PW'(num_reg) * PW'(RECIP);
    assign quo_calc = KEY_WIDTH'(prod >> SH);
    assign back     = PW'(quo_reg) * PW'(SLOT_COUNT);
    assign rem_calc = num_reg - KEY_WIDTH'(back);

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        home_next  = home_reg;
        step_next  = step_reg;
        small_next = small_reg;
        pass_next  = pass_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    num_next   = key;
                    small_next = (key < KEY_WIDTH'(SLOT_COUNT));
                    pass_next  = 1'b0;
                    state_next = S_QUO;
                end
            end
            S_QUO:
            begin
                quo_next   = quo_calc;
                state_next = S_REM;
            end
            S_REM:
            begin
                if (!pass_reg)
                begin
                    home_next  = rem_calc[AW-1:0];
                    num_next   = quo_reg;
                    pass_next  = 1'b1;
                    state_next = S_QUO;
                end
                else
                begin
                    if (small_reg || rem_calc == '0)
                        step_next = AW'(1);
                    else
                        step_next = rem_calc[AW-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            num_reg   <= '0;
            quo_reg   <= '0;
            home_reg  <= '0;
            step_reg  <= '0;
            small_reg <= 1'b0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            num_reg   <= num_next;
            quo_reg   <= quo_next;
            home_reg  <= home_next;
            step_reg  <= step_next;
            small_reg <= small_next;
            pass_reg  <= pass_next;
        end
    end

    assign done = (state_reg == S_DONE);
    assign home = home_reg;
    assign step = step_reg;

endmodule

// ===== rtl/core/brent_hash_insert_lookup.sv =====
// A query probes its chain until the key matches or every slot has been probed.
// An insert walks its chain to a free slot, then rehashes each occupant checked
// and walks its free slots (up to 30 when none is free), and rehashes again for
// a move; each hash runs on one shared reciprocal multiplier. One item at a time.
// Reset clears all valid bits at once; slot keys are undefined until written.
// ----------------------------------------------------------------------------
// brent_hash_insert_lookup
// Open-addressed hash table with double hashing and Brent's relocation.
// ----------------------------------------------------------------------------
module brent_hash_insert_lookup (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bhil_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output bhil_pkg::rsp_t out_data
);

    localparam int unsigned SLOT_COUNT = bhil_pkg::SLOT_COUNT;
    localparam int unsigned KEY_WIDTH  = bhil_pkg::KEY_W;
    localparam int unsigned AW         = $clog2(SLOT_COUNT);
    localparam int unsigned NW         = $clog2(SLOT_COUNT + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH_NEW,
        S_WAIT_NEW,
        S_CHAIN,
        S_CAND,
        S_HASH_OCC,
        S_WAIT_OCC,
        S_FREE,
        S_MOVE_HASH,
        S_MOVE_WAIT,
        S_MOVE,
        S_WRITE,
        S_QUERY,
        S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_COUNT-1:0] vld_reg, vld_next;
    logic [KEY_WIDTH-1:0]  mem [SLOT_COUNT];
    logic [KEY_WIDTH-1:0]  rd_reg;
    logic                  op_reg, op_next;
    logic [KEY_WIDTH-1:0]  key_reg, key_next;
    logic [AW-1:0]         home_reg, home_next;
    logic [AW-1:0]         c_reg, c_next;
    logic [AW-1:0]         a_reg, a_next;
    logic [NW-1:0]         s_reg, s_next;
    logic [NW-1:0]         j_reg, j_next;
    logic [AW-1:0]         p_reg, p_next;
    logic [NW:0]           best_reg, best_next;
    logic [NW-1:0]         bi_reg, bi_next;
    logic [AW-1:0]         bp_reg, bp_next;
    logic                  mv_reg, mv_next;
    logic [AW-1:0]         q_reg, q_next;
    logic [AW-1:0]         f_reg, f_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [KEY_WIDTH-1:0]  old_reg, old_next;
    bhil_pkg::rsp_t        rsp_reg, rsp_next;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [KEY_WIDTH-1:0]  wdata;
    logic [AW-1:0]         raddr;
    logic                  hstart;
    logic [KEY_WIDTH-1:0]  hkey;
    logic                  hdone;
    logic [AW-1:0]         hhome, hstep;
    logic [AW-1:0]         adv_base, adv_step, adv;
    logic [AW:0]           adv_sum;

    bhil_hash #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_WIDTH  (KEY_WIDTH),
        .AW         (AW)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hstart),
        .key   (hkey),
        .done  (hdone),
        .home  (hhome),
        .step  (hstep)
    );

    always_comb
    begin
        case (state_reg)
            S_FREE, S_MOVE:
            begin
                adv_base = (state_reg == S_FREE) ? f_reg : bp_reg;
                adv_step = q_reg;
            end
            S_CAND:
            begin
                adv_base = p_reg;
                adv_step = c_reg;
            end
            default:
            begin
                adv_base = a_reg;
                adv_step = c_reg;
            end
        endcase
        adv_sum = {1'b0, adv_base} + {1'b0, adv_step};
        if (adv_sum >= (AW+1)'(SLOT_COUNT))
            adv_sum = adv_sum - (AW+1)'(SLOT_COUNT);
        adv = adv_sum[AW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        vld_next   = vld_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        home_next  = home_reg;
        c_next     = c_reg;
        a_next     = a_reg;
        s_next     = s_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        best_next  = best_reg;
        bi_next    = bi_reg;
        bp_next    = bp_reg;
        mv_next    = mv_reg;
        q_next     = q_reg;
        f_next     = f_reg;
        n_next     = n_reg;
        old_next   = old_reg;
        rsp_next   = rsp_reg;
        we         = 1'b0;
        waddr      = a_reg;
        wdata      = key_reg;
        hstart     = 1'b0;
        hkey       = key_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.opcode;
                    key_next   = KEY_WIDTH'(in_data.key);
                    state_next = S_HASH_NEW;
                end
            end
            S_HASH_NEW:
            begin
                hstart     = 1'b1;
                state_next = S_WAIT_NEW;
            end
            S_WAIT_NEW:
            begin
                if (hdone)
                begin
                    home_next = hhome;
                    c_next    = hstep;
                    a_next    = hhome;
                    s_next    = NW'(1);
                    n_next    = NW'(1);
                    if (op_reg == bhil_pkg::OP_QUERY)
                        state_next = S_QUERY;
                    else if (&vld_reg)
                    begin
                        rsp_next   = '{bhil_pkg::ST_FULL, '0, '0};
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_CHAIN;
                end
            end
            S_QUERY:
            begin
                if (vld_reg[a_reg] && rd_reg == key_reg)
                begin
                    rsp_next   = '{bhil_pkg::ST_OK, bhil_pkg::OUT_W'(a_reg),
                                   bhil_pkg::OUT_W'(n_reg)};
                    state_next = S_OUT;
                end
                else if (n_reg == NW'(SLOT_COUNT))
                begin
                    rsp_next   = '{bhil_pkg::ST_NOT_FOUND, '0, '0};
                    state_next = S_OUT;
                end
                else
                begin
                    a_next = adv;
                    n_next = n_reg + 1'b1;
                end
            end
            S_CHAIN:
            begin
                if (!vld_reg[a_reg])
                begin
                    best_next  = {1'b0, s_reg};
                    mv_next    = 1'b0;
                    j_next     = NW'(1);
                    p_next     = home_reg;
                    state_next = S_CAND;
                end
                else if (s_reg == NW'(SLOT_COUNT))
                begin
                    rsp_next   = '{bhil_pkg::ST_FULL, '0, '0};
                    state_next = S_OUT;
                end
                else
                begin
                    a_next = adv;
                    s_next = s_reg + 1'b1;
                end
            end
            S_CAND:
            begin
                if (j_reg >= s_reg)
                    state_next = mv_reg ? S_MOVE_HASH : S_WRITE;
                else
                begin
                    old_next   = rd_reg;
                    state_next = S_HASH_OCC;
                end
            end
            S_HASH_OCC:
            begin
                hstart     = 1'b1;
                hkey       = old_reg;
                state_next = S_WAIT_OCC;
            end
            S_WAIT_OCC:
            begin
                if (hdone)
                begin
                    q_next     = hstep;
                    f_next     = p_reg;
                    n_next     = '0;
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                if (n_reg != '0 && !vld_reg[f_reg])
                begin
                    if (({1'b0, n_reg} + {1'b0, j_reg}) < best_reg)
                    begin
                        best_next = {1'b0, n_reg} + {1'b0, j_reg};
                        bi_next   = n_reg;
                        bp_next   = p_reg;
                        mv_next   = 1'b1;
                    end
                    state_next = S_CAND;
                end
                else if (n_reg == NW'(SLOT_COUNT - 1))
                    state_next = S_CAND;
                else
                begin
                    f_next = adv;
                    n_next = n_reg + 1'b1;
                end
                if (state_next == S_CAND)
                begin
                    j_next = j_reg + 1'b1;
                    p_next = (({1'b0, p_reg} + {1'b0, c_reg}) >= (AW+1)'(SLOT_COUNT))
                             ? AW'({1'b0, p_reg} + {1'b0, c_reg} - (AW+1)'(SLOT_COUNT))
                             : AW'({1'b0, p_reg} + {1'b0, c_reg});
                end
            end
            S_MOVE_HASH:
            begin
                old_next   = rd_reg;
                state_next = S_MOVE_WAIT;
                hstart     = 1'b0;
            end
            S_MOVE_WAIT:
            begin
                hstart     = 1'b1;
                hkey       = old_reg;
                state_next = S_MOVE;
                n_next     = '0;
                f_next     = bp_reg;
            end
            S_MOVE:
            begin
                if (hdone)
                begin
                    q_next = hstep;
                    n_next = NW'(1);
                end
                else if (n_reg != '0)
                begin
                    if (n_reg > bi_reg)
                    begin
                        we         = 1'b1;
                        waddr      = f_reg;
                        wdata      = old_reg;
                        vld_next[f_reg] = 1'b1;
                        a_next     = bp_reg;
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        f_next = (({1'b0, f_reg} + {1'b0, q_reg}) >= (AW+1)'(SLOT_COUNT))
                                 ? AW'({1'b0, f_reg} + {1'b0, q_reg} - (AW+1)'(SLOT_COUNT))
                                 : AW'({1'b0, f_reg} + {1'b0, q_reg});
                        n_next = n_reg + 1'b1;
                    end
                end
            end
            S_WRITE:
            begin
                if (mv_reg && state_reg == S_WRITE && a_reg != bp_reg)
                    a_next = bp_reg;
                we              = 1'b1;
                waddr           = mv_reg ? bp_reg : a_reg;
                wdata           = key_reg;
                vld_next[waddr] = 1'b1;
                rsp_next        = '{bhil_pkg::ST_OK, bhil_pkg::OUT_W'(waddr), '0};
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_next)
            S_CAND:
                raddr = p_next;
            S_MOVE_HASH:
                raddr = bp_next;
            default:
                raddr = a_next;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= '0;
            op_reg    <= 1'b0;
            key_reg   <= '0;
            home_reg  <= '0;
            c_reg     <= '0;
            a_reg     <= '0;
            s_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
            best_reg  <= '0;
            bi_reg    <= '0;
            bp_reg    <= '0;
            mv_reg    <= 1'b0;
            q_reg     <= '0;
            f_reg     <= '0;
            n_reg     <= '0;
            old_reg   <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            op_reg    <= op_next;
            key_reg   <= key_next;
            home_reg  <= home_next;
            c_reg     <= c_next;
            a_reg     <= a_next;
            s_reg     <= s_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
            best_reg  <= best_next;
            bi_reg    <= bi_next;
            bp_reg    <= bp_next;
            mv_reg    <= mv_next;
            q_reg     <= q_next;
            f_reg     <= f_next;
            n_reg     <= n_next;
            old_reg   <= old_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[raddr];
        if (we)
            mem[waddr] <= wdata;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = rsp_reg;

endmodule

// ===== verif/tb_brent_hash_insert_lookup.sv =====
// ----------------------------------------------------------------------------
// tb_brent_hash_insert_lookup
// Drives inserts and queries into the hash table under random valid/ready
// gaps and checks every response against an in-bench table model.
// ----------------------------------------------------------------------------
module tb_brent_hash_insert_lookup;

    localparam int TSIZE = bhil_pkg::SLOT_COUNT;
    localparam int LIMIT = 10000000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    bhil_pkg::req_t in_data;
    logic           out_valid;
    logic           out_ready;
    bhil_pkg::rsp_t out_data;

    brent_hash_insert_lookup DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    bit             occ[TSIZE];
    logic [15:0]    keys[TSIZE];
    bhil_pkg::req_t pending_reqs[$];
    bhil_pkg::rsp_t expected_rsps[$];
    int             errors;
    int             cycle;
    int             in_wait;
    int             out_wait;
    bit             stim_done;

    function automatic int step_for(logic [15:0] k);
        int c;
        if (k < TSIZE)
            return 1;
        c = (k / TSIZE) % TSIZE;
        return (c == 0) ? 1 : c;
    endfunction

    function automatic int free_dist(int start, int c);
        int a;
        a = start;
        for (int n = 1; n < TSIZE; n++)
        begin
            a = (a + c) % TSIZE;
            if (!occ[a])
                return n;
        end
        return 0;
    endfunction

    function automatic bhil_pkg::rsp_t table_apply(bhil_pkg::req_t r);
        bhil_pkg::rsp_t res;
        int home, c, a, s, p, best, best_i, best_p, i, dst, q, n;
        bit any_free, moving;
        logic [15:0] k;
        k = r.key;
        home = k % TSIZE;
        c = step_for(k);
        res.status = bhil_pkg::ST_OK;
        res.slot = '0;
        res.probes = '0;
        if (r.opcode == bhil_pkg::OP_QUERY)
        begin
            a = home;
            for (n = 1; n <= TSIZE; n++)
            begin
                if (occ[a] && keys[a] == k)
                begin
                    res.slot = a[4:0];
                    res.probes = n[4:0];
                    return res;
                end
                a = (a + c) % TSIZE;
            end
            res.status = bhil_pkg::ST_NOT_FOUND;
            return res;
        end
        any_free = 0;
        for (n = 0; n < TSIZE; n++)
            if (!occ[n])
                any_free = 1;
        a = home;
        s = 1;
        while (any_free && occ[a] && s < TSIZE)
        begin
            a = (a + c) % TSIZE;
            s++;
        end
        if (!any_free || occ[a])
        begin
            res.status = bhil_pkg::ST_FULL;
            return res;
        end
        best = s;
        best_i = 0;
        best_p = 0;
        moving = 0;
        p = home;
        for (int j = 1; j < s; j++)
        begin
            i = free_dist(p, step_for(keys[p]));
            if (i != 0 && i + j < best)
            begin
                best = i + j;
                best_i = i;
                best_p = p;
                moving = 1;
            end
            p = (p + c) % TSIZE;
        end
        if (moving)
        begin
            q = step_for(keys[best_p]);
            dst = best_p;
            for (int m = 0; m < best_i; m++)
                dst = (dst + q) % TSIZE;
            keys[dst] = keys[best_p];
            occ[dst] = 1;
            keys[best_p] = k;
            a = best_p;
        end
        else
        begin
            keys[a] = k;
            occ[a] = 1;
        end
        res.slot = a[4:0];
        return res;
    endfunction

    function automatic logic [15:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, TSIZE - 1));
            1: return 16'($urandom_range(0, 1023));
            2: return 16'($urandom_range(0, 40) * TSIZE);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_req(bhil_pkg::opcode_t op, logic [15:0] k);
        bhil_pkg::req_t r;
        r.opcode = op;
        r.key = k;
        pending_reqs.push_back(r);
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        logic [15:0] inserted[$];
        logic [15:0] k;
        rst_n = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        push_req(bhil_pkg::OP_QUERY, 16'd0);
        push_req(bhil_pkg::OP_INSERT, 16'd0);
        push_req(bhil_pkg::OP_INSERT, 16'd0);
        push_req(bhil_pkg::OP_QUERY, 16'd0);
        push_req(bhil_pkg::OP_INSERT, 16'hFFFF);
        push_req(bhil_pkg::OP_QUERY, 16'hFFFF);
        push_req(bhil_pkg::OP_INSERT, 16'd30);
        push_req(bhil_pkg::OP_INSERT, 16'd31);
        push_req(bhil_pkg::OP_INSERT, 16'd62);
        push_req(bhil_pkg::OP_INSERT, 16'd961);
        push_req(bhil_pkg::OP_INSERT, 16'd992);
        push_req(bhil_pkg::OP_QUERY, 16'd992);
        push_req(bhil_pkg::OP_QUERY, 16'd12345);
        push_req(bhil_pkg::OP_QUERY, 16'h5555);
        push_req(bhil_pkg::OP_QUERY, 16'hAAAA);
        for (int i = 0; i < 24; i++)
            push_req(bhil_pkg::OP_INSERT, 16'(1 + i * 31));
        push_req(bhil_pkg::OP_INSERT, 16'd7);
        push_req(bhil_pkg::OP_QUERY, 16'd249);
        // random mix of inserts and queries: the table only resets once, so it fills up
        for (int i = 0; i < 1600; i++)
        begin
            if ($urandom_range(0, 2) == 0 || inserted.size() == 0)
            begin
                k = pick_key();
                inserted.push_back(k);
                push_req(bhil_pkg::OP_INSERT, k);
            end
            else if ($urandom_range(0, 3) == 0)
                push_req(bhil_pkg::OP_QUERY, pick_key());
            else
                push_req(bhil_pkg::OP_QUERY,
                         inserted[$urandom_range(0, inserted.size() - 1)]);
        end
        stim_done = 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            in_data <= '0;
            in_wait <= 0;
        end
        else if (in_valid && !in_ready)
        begin
            in_valid <= 1;
        end
        else if (in_wait > 0)
        begin
            in_valid <= 0;
            in_wait <= in_wait - 1;
        end
        else if (pending_reqs.size() > 0)
        begin
            in_data <= pending_reqs[0];
            expected_rsps.push_back(table_apply(pending_reqs.pop_front()));
            in_valid <= 1;
            in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        end
        else
            in_valid <= 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        bhil_pkg::rsp_t exp_rsp;
        if (!rst_n)
        begin
            out_ready <= 0;
            out_wait <= 0;
            errors <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t unexpected beat %p", $time, out_data);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_rsp = expected_rsps.pop_front();
                    if (exp_rsp !== out_data)
                    begin
                        $display("%0t mismatch expected %p actual %p", $time, exp_rsp,
                                 out_data);
                        errors <= errors + 1;
                    end
                end
                out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                out_ready <= 0;
            end
            else if (out_wait > 0)
            begin
                out_wait <= out_wait - 1;
                out_ready <= 0;
            end
            else
                out_ready <= 1;
        end
    end

    initial
    begin
        cycle = 0;
        stim_done = 0;
        wait (stim_done);
        while ((pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_valid)
               && cycle < LIMIT)
        begin
            @(posedge clk);
            cycle++;
        end
        repeat (200) @(posedge clk);
        if (cycle >= LIMIT || expected_rsps.size() > 0)
            $display("CHECK FAILED");
        else if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
